>>> rtl/core/x8f_pkg.sv
// ============================================================================
// x8f_pkg: shared definitions for the xor8 filter lookup block
// Field widths, hash constants, operation and register codes, and the
// side-band record that travels with every item through the pipeline.
// ============================================================================
package x8f_pkg;

    localparam int KEY_W   = 64;
    localparam int BLEN_W  = 13;
    localparam int IDX_W   = 14;
    localparam int FP_W    = 8;
    localparam int HALF_W  = 32;

    localparam int DEFAULT_MAX_BLOCK_CELLS = 4096;

    // splitmix64 finalizer constants.
    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int MIX_SHR_A = 30;
    localparam int MIX_SHR_B = 27;
    localparam int MIX_SHR_C = 31;

    // Rotations that pick the second and third cells.
    localparam int ROT_B1 = 21;
    localparam int ROT_B2 = 42;

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    typedef enum logic {
        REG_HASH_SEED    = 1'b0,
        REG_BLOCK_LENGTH = 1'b1
    } reg_idx_t;

    // Item fields carried alongside the hash.
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [FP_W-1:0]  entry_value;
    } side_t;

    // Query bookkeeping that waits for the table read.
    typedef struct packed {
        logic            valid;
        logic            no_filter;
        logic [FP_W-1:0] fingerprint;
    } qry_t;

endpackage

>>> rtl/core/x8f_mixer.sv
// ============================================================================
// x8f_mixer: five-stage splitmix64 finalizer
// Each 64-bit multiply keeps only its low half and is split into three
// 32x32 partial products in one stage, summed in the next.
// ============================================================================
module x8f_mixer
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [x8f_pkg::KEY_W-1:0] in_key,
    input  logic [x8f_pkg::KEY_W-1:0] seed,
    input  x8f_pkg::side_t           in_side,
    output logic                     out_valid,
    output logic [x8f_pkg::KEY_W-1:0] out_hash,
    output x8f_pkg::side_t           out_side
);
    import x8f_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0]   valid_reg;
    side_t             side_reg [NSTG];

    logic [KEY_W-1:0]  s1_reg, s1_next;
    logic [KEY_W-1:0]  s2_lo_reg, s2_lo_next;
    logic [HALF_W-1:0] s2_x_reg, s2_x_next;
    logic [HALF_W-1:0] s2_y_reg, s2_y_next;
    logic [KEY_W-1:0]  s3_reg, s3_next;
    logic [KEY_W-1:0]  s4_lo_reg, s4_lo_next;
    logic [HALF_W-1:0] s4_x_reg, s4_x_next;
    logic [HALF_W-1:0] s4_y_reg, s4_y_next;
    logic [KEY_W-1:0]  s5_reg, s5_next;

    logic [HALF_W-1:0] pa_x, pa_y, pb_x, pb_y;
    logic [KEY_W-1:0]  sum3, sum5;

    always_comb
    begin
        s1_next = (in_key ^ seed) ^ ((in_key ^ seed) >> MIX_SHR_A);

        s2_lo_next = KEY_W'(s1_reg[HALF_W-1:0]) * KEY_W'(MIX_MUL_A[HALF_W-1:0]);
        pa_x       = s1_reg[HALF_W-1:0] * MIX_MUL_A[KEY_W-1:HALF_W];
        pa_y       = s1_reg[KEY_W-1:HALF_W] * MIX_MUL_A[HALF_W-1:0];
        s2_x_next  = pa_x;
        s2_y_next  = pa_y;

        sum3    = s2_lo_reg + {s2_x_reg + s2_y_reg, {HALF_W{1'b0}}};
        s3_next = sum3 ^ (sum3 >> MIX_SHR_B);

        s4_lo_next = KEY_W'(s3_reg[HALF_W-1:0]) * KEY_W'(MIX_MUL_B[HALF_W-1:0]);
        pb_x       = s3_reg[HALF_W-1:0] * MIX_MUL_B[KEY_W-1:HALF_W];
        pb_y       = s3_reg[KEY_W-1:HALF_W] * MIX_MUL_B[HALF_W-1:0];
        s4_x_next  = pb_x;
        s4_y_next  = pb_y;

        sum5    = s4_lo_reg + {s4_x_reg + s4_y_reg, {HALF_W{1'b0}}};
        s5_next = sum5 ^ (sum5 >> MIX_SHR_C);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 1; i < NSTG; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        s1_reg    <= s1_next;
        s2_lo_reg <= s2_lo_next;
        s2_x_reg  <= s2_x_next;
        s2_y_reg  <= s2_y_next;
        s3_reg    <= s3_next;
        s4_lo_reg <= s4_lo_next;
        s4_x_reg  <= s4_x_next;
        s4_y_reg  <= s4_y_next;
        s5_reg    <= s5_next;
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_hash  = s5_reg;
    assign out_side  = side_reg[NSTG-1];

endmodule

>>> rtl/core/x8f_index.sv
// ============================================================================
// x8f_index: cell selection and table access requests
// Reduces three 32-bit slices of the hash into block cells in one stage,
// adds the block offsets in the next, and turns write items into table writes.
// ============================================================================
module x8f_index
#(
    parameter int MAX_BLOCK_CELLS = x8f_pkg::DEFAULT_MAX_BLOCK_CELLS,
    parameter int TBL_AW          = $clog2(3 * MAX_BLOCK_CELLS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [x8f_pkg::KEY_W-1:0]  in_hash,
    input  x8f_pkg::side_t             in_side,
    input  logic [x8f_pkg::BLEN_W-1:0] block_length,
    output logic [TBL_AW-1:0]          raddr0,
    output logic [TBL_AW-1:0]          raddr1,
    output logic [TBL_AW-1:0]          raddr2,
    output logic                       wen,
    output logic [TBL_AW-1:0]          waddr,
    output logic [x8f_pkg::FP_W-1:0]   wdata,
    output x8f_pkg::qry_t              qry
);
    import x8f_pkg::*;

    localparam int TABLE_CELLS = 3 * MAX_BLOCK_CELLS;
    localparam int PROD_W      = HALF_W + BLEN_W;

    logic [BLEN_W-1:0] cells;
    logic [TBL_AW-1:0] cells_a;
    logic [KEY_W-1:0]  rot1, rot2;
    logic [PROD_W-1:0] prod0, prod1, prod2;

    // Stage 6 registers.
    logic              v6_reg;
    side_t             side6_reg;
    qry_t              q6_next, q6_reg;
    logic [BLEN_W-1:0] r0_reg, r1_reg, r2_reg;

    // Stage 7 registers.
    logic              wen_reg, wen_next;
    logic [TBL_AW-1:0] waddr_reg, waddr_next;
    logic [FP_W-1:0]   wdata_reg;
    logic [TBL_AW-1:0] a0_reg, a1_reg, a2_reg;
    qry_t              q7_reg, q7_next;

    always_comb
    begin
        // Block lengths above MAX_BLOCK_CELLS are clamped to the largest block.
        if (32'(block_length) > 32'(MAX_BLOCK_CELLS))
        begin
            cells = BLEN_W'(MAX_BLOCK_CELLS);
        end
        else
        begin
            cells = block_length;
        end
        cells_a = TBL_AW'(cells);

        rot1  = {in_hash[KEY_W-1-ROT_B1:0], in_hash[KEY_W-1:KEY_W-ROT_B1]};
        rot2  = {in_hash[KEY_W-1-ROT_B2:0], in_hash[KEY_W-1:KEY_W-ROT_B2]};
        prod0 = PROD_W'(in_hash[HALF_W-1:0]) * PROD_W'(cells);
        prod1 = PROD_W'(rot1[HALF_W-1:0]) * PROD_W'(cells);
        prod2 = PROD_W'(rot2[HALF_W-1:0]) * PROD_W'(cells);

        q6_next.valid       = in_valid && (in_side.op == OP_QUERY);
        q6_next.no_filter   = (block_length == '0);
        q6_next.fingerprint = in_hash[FP_W-1:0] ^ in_hash[HALF_W+FP_W-1:HALF_W]
                              ^ in_hash[16+FP_W-1:16];

        wen_next   = v6_reg && (side6_reg.op == OP_WRITE)
                     && (32'(side6_reg.entry_index) < 32'(TABLE_CELLS));
        waddr_next = TBL_AW'(side6_reg.entry_index);
        q7_next    = q6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg  <= 1'b0;
            q6_reg  <= '0;
            wen_reg <= 1'b0;
            q7_reg  <= '0;
        end
        else
        begin
            v6_reg  <= in_valid;
            q6_reg  <= q6_next;
            wen_reg <= wen_next;
            q7_reg  <= q7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side6_reg          <= in_side;
        r0_reg             <= prod0[PROD_W-1:HALF_W];
        r1_reg             <= prod1[PROD_W-1:HALF_W];
        r2_reg             <= prod2[PROD_W-1:HALF_W];

        waddr_reg          <= waddr_next;
        wdata_reg          <= side6_reg.entry_value;
        a0_reg             <= TBL_AW'(r0_reg);
        a1_reg             <= cells_a + TBL_AW'(r1_reg);
        a2_reg             <= cells_a + cells_a + TBL_AW'(r2_reg);
    end

    assign raddr0 = a0_reg;
    assign raddr1 = a1_reg;
    assign raddr2 = a2_reg;
    assign wen    = wen_reg;
    assign waddr  = waddr_reg;
    assign wdata  = wdata_reg;
    assign qry    = q7_reg;

endmodule

>>> rtl/core/x8f_ram.sv
// ============================================================================
// x8f_ram: fingerprint table copy
// One write port and one read port with registered read data.
// ============================================================================
module x8f_ram
#(
    parameter int DEPTH = 3 * x8f_pkg::DEFAULT_MAX_BLOCK_CELLS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     wen,
    input  logic [AW-1:0]            waddr,
    input  logic [x8f_pkg::FP_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [x8f_pkg::FP_W-1:0] rdata
);
    import x8f_pkg::*;

    logic [FP_W-1:0] mem [DEPTH];
    logic [FP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/xor8_filter_lookup_top.sv
// ============================================================================
// xor8_filter_lookup_top: pipelined xor8 filter membership lookup
// Loads fingerprint bytes into the table and answers membership queries on
// 64-bit keys, one item per clock.
// ============================================================================
//
//  Channel   Signals                                          Direction
//  --------  -----------------------------------------------  ---------
//  item      start, busy, op, lookup_key, entry_index,        in/out
//            entry_value
//  result    done, maybe_present                              out
//  config    psel, penable, pwrite, paddr, pwdata, prdata,    in/out
//            pready
//
//  An item is taken at every clock edge where start is high; busy stays low,
//  so a new item may enter in every cycle. A query passes five stages of
//  hash mixing, two of cell selection, one table read and one output
//  register before it answers. A write item passes the mixing and cell
//  selection stages, then updates the table and produces no result; since
//  writes and queries pass the table in order, a query sees every write taken
//  before it. The result receiver cannot stall, so nothing in the pipeline
//  ever holds. Reset clears the pipeline valid bits and the two registers;
//  the table itself is not cleared and holds whatever was last written.
//
module xor8_filter_lookup_top
#(
    parameter int MAX_BLOCK_CELLS = x8f_pkg::DEFAULT_MAX_BLOCK_CELLS
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic [x8f_pkg::KEY_W-1:0]  lookup_key,
    input  logic [x8f_pkg::IDX_W-1:0]  entry_index,
    input  logic [x8f_pkg::FP_W-1:0]   entry_value,

    output logic                       done,
    output logic                       maybe_present,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [x8f_pkg::KEY_W-1:0]  pwdata,
    output logic [x8f_pkg::KEY_W-1:0]  prdata,
    output logic                       pready
);
    import x8f_pkg::*;

    localparam int TABLE_CELLS = 3 * MAX_BLOCK_CELLS;
    localparam int TBL_AW      = $clog2(TABLE_CELLS);
    localparam int REG_LSB     = 3;

    // Configuration registers, 64-bit slots at byte offsets 0 and 8.
    logic [KEY_W-1:0]  seed_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_sel;

    side_t             in_side;
    logic              mix_valid;
    logic [KEY_W-1:0]  mix_hash;
    side_t             mix_side;

    logic [TBL_AW-1:0] raddr0, raddr1, raddr2, waddr;
    logic              wen;
    logic [FP_W-1:0]   wdata;
    logic [FP_W-1:0]   rdata0, rdata1, rdata2;
    qry_t              qry, qry_reg;

    logic              done_reg;
    logic              hit_reg, hit_next;

    // The pipeline never stalls, so an item is accepted on any start.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Register file. The register is chosen by the 8-byte slot; the low
    // address bits are ignored.
    // ------------------------------------------------------------------
    assign cfg_sel = reg_idx_t'(paddr[REG_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            blen_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_HASH_SEED:    seed_reg <= pwdata;
                REG_BLOCK_LENGTH: blen_reg <= pwdata[BLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_HASH_SEED:    prdata = seed_reg;
            REG_BLOCK_LENGTH: prdata = KEY_W'(blen_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Hash pipeline. Write items ride along unchanged so that they reach
    // the table in order with the queries.
    // ------------------------------------------------------------------
    assign in_side.op          = op;
    assign in_side.entry_index = entry_index;
    assign in_side.entry_value = entry_value;

    x8f_mixer u_mixer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_key    (lookup_key),
        .seed      (seed_reg),
        .in_side   (in_side),
        .out_valid (mix_valid),
        .out_hash  (mix_hash),
        .out_side  (mix_side)
    );

    x8f_index
    #(
        .MAX_BLOCK_CELLS (MAX_BLOCK_CELLS),
        .TBL_AW          (TBL_AW)
    )
    u_index
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mix_valid),
        .in_hash      (mix_hash),
        .in_side      (mix_side),
        .block_length (blen_reg),
        .raddr0       (raddr0),
        .raddr1       (raddr1),
        .raddr2       (raddr2),
        .wen          (wen),
        .waddr        (waddr),
        .wdata        (wdata),
        .qry          (qry)
    );

    // ------------------------------------------------------------------
    // Three identical copies of the table give three reads per cycle.
    // Every write goes to all copies.
    // ------------------------------------------------------------------
    x8f_ram #(.DEPTH(TABLE_CELLS), .AW(TBL_AW)) u_ram0
    (
        .clk   (clk),
        .wen   (wen),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    x8f_ram #(.DEPTH(TABLE_CELLS), .AW(TBL_AW)) u_ram1
    (
        .clk   (clk),
        .wen   (wen),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    x8f_ram #(.DEPTH(TABLE_CELLS), .AW(TBL_AW)) u_ram2
    (
        .clk   (clk),
        .wen   (wen),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    // ------------------------------------------------------------------
    // Query bookkeeping is registered alongside the table read, then the
    // three bytes are compared with the fingerprint. With no filter
    // loaded every query answers maybe present.
    // ------------------------------------------------------------------
    assign hit_next = qry_reg.no_filter
                      || ((rdata0 ^ rdata1 ^ rdata2) == qry_reg.fingerprint);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qry_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            qry_reg  <= qry;
            done_reg <= qry_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign done          = done_reg;
    assign maybe_present = hit_reg;

endmodule
